[src/seven_segment_serial_display_driver_core_macros.svh]
// Assertion macros for the seven-segment serial display driver core.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SSD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define SSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ssd_pkg.sv]
// Shared types, constants and the segment table of the display driver.
// No dependencies; imported by every module of the block.
package ssd_pkg;

  // Field widths.
  localparam int unsigned ValueW = 10;
  localparam int unsigned TargetW = 2;
  localparam int unsigned DigitW = 4;
  localparam int unsigned PatW = 8;

  // Default depth of the queue between front and back.
  localparam int unsigned FifoDepthDefault = 2;

  // Serial run layout: 8 ones pulses, 8 tens pulses, 9 hundreds pulses.
  localparam int unsigned Pulses = 25;
  localparam int unsigned CntW = 5;
  localparam logic [CntW-1:0] CntTensStart = 5'd8;
  localparam logic [CntW-1:0] CntHundStart = 5'd16;
  localparam logic [CntW-1:0] CntLast = 5'd24;

  // Target register codes.
  localparam logic [TargetW-1:0] TgtOnes = 2'd0;
  localparam logic [TargetW-1:0] TgtTens = 2'd1;
  localparam logic [TargetW-1:0] TgtHund = 2'd2;

  // Dot segment bit and the value at which it lights.
  localparam logic [PatW-1:0] DotSegment = 8'h80;
  localparam logic [ValueW-1:0] DotThreshold = 10'd1000;

  // Inverted (active-low) patterns for one value, as they go to the back end.
  typedef struct packed {
    logic [PatW-1:0] ones;
    logic [PatW-1:0] tens;
    logic [PatW-1:0] hund;
  } ssd_pat_t;

  // Seven-segment table, bit 0 drives segment F and bit 7 the dot.
  function automatic logic [PatW-1:0] seg_lookup(input logic [DigitW-1:0] digit);
    logic [PatW-1:0] pat;
    case (digit)
      4'd0: pat = 8'h7D;
      4'd1: pat = 8'h30;
      4'd2: pat = 8'h6E;
      4'd3: pat = 8'h7A;
      4'd4: pat = 8'h33;
      4'd5: pat = 8'h5B;
      4'd6: pat = 8'h5F;
      4'd7: pat = 8'h70;
      4'd8: pat = 8'h7F;
      4'd9: pat = 8'h7B;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

[src/seven_segment_serial_display_driver_core.sv]
// Seven-segment serial display driver: value in, 25 serial pulse beats out.
// Throughput: one pulse per cycle while a pattern waits and the result slot is free or popped.
// The two-step divide in the front overlaps the previous value's serial run.
// Reset (asynchronous, active low) empties the queue and the result register.
// Depends on ssd_pkg, ssd_front, ssd_fifo, ssd_back and the macros header.
`include "seven_segment_serial_display_driver_core_macros.svh"

module seven_segment_serial_display_driver_core #(
  parameter int unsigned FifoDepth = ssd_pkg::FifoDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [ssd_pkg::ValueW-1:0]  value_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [ssd_pkg::TargetW-1:0] target_register_o,
  output logic                        data_bit_o,
  output logic                        last_o
);
  import ssd_pkg::*;

  logic     wr_valid, wr_ready;
  ssd_pat_t wr_data;
  logic     rd_valid, rd_pop;
  ssd_pat_t rd_data;

  // Front end: accept and digit split.
  ssd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .value_i    (value_i),
    .wr_valid_o (wr_valid),
    .wr_ready_i (wr_ready),
    .wr_data_o  (wr_data)
  );

  // Pattern queue.
  ssd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_ready_o (wr_ready),
    .wr_data_i  (wr_data),
    .rd_valid_o (rd_valid),
    .rd_pop_i   (rd_pop),
    .rd_data_o  (rd_data)
  );

  // Back end: serializer.
  ssd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rd_valid_i        (rd_valid),
    .rd_pop_o          (rd_pop),
    .rd_data_i         (rd_data),
    .empty             (empty),
    .pop               (pop),
    .target_register_o (target_register_o),
    .data_bit_o        (data_bit_o),
    .last_o            (last_o)
  );

  // Checks on the serializer and the queue.
  `SSD_ASSERT_IMPL(a_last_on_hund, !empty && last_o, target_register_o == TgtHund, "last beat not on hundreds register")
  `SSD_ASSERT_ALWAYS(a_target_range, empty || (target_register_o != 2'd3), "target register code out of range")
  `SSD_ASSERT_NEXT(a_run_unbroken, !empty && pop && !last_o, !empty, "gap inside a serial run")
  `SSD_ASSERT_IMPL(a_pop_only_valid, rd_pop, rd_valid, "queue popped while empty")

endmodule

[src/ssd_front.sv]
// Front end: accepts values and splits them into segment patterns in two steps.
// Depends on ssd_pkg; feeds ssd_fifo.
module ssd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [ssd_pkg::ValueW-1:0] value_i,
  output logic                       wr_valid_o,
  input  logic                       wr_ready_i,
  output ssd_pkg::ssd_pat_t          wr_data_o
);
  import ssd_pkg::*;

  typedef enum logic [1:0] {
    FrIdle,
    FrDiv1,
    FrDiv2
  } fr_state_e;

  fr_state_e         state_q, state_d;
  logic [ValueW-1:0] val_q;
  logic [6:0]        q1_q, q1_d;
  logic [DigitW-1:0] ones_q, ones_d;
  logic              dot_q, dot_d;

  logic              accept;
  logic [17:0]       prod1;
  logic [9:0]        q1x10;
  logic [9:0]        ones_full;
  logic [14:0]       prod2;
  logic [3:0]        q2;
  logic [6:0]        q2x10;
  logic [6:0]        tens_full;
  logic [DigitW-1:0] hund;
  logic [PatW-1:0]   hund_raw;

  // New value is taken when idle or when the finished item leaves this cycle.
  assign full   = !((state_q == FrIdle) || ((state_q == FrDiv2) && wr_ready_i));
  assign accept = push && !full;

  // First step: value / 10 by reciprocal multiply, exact below 1029.
  always_comb begin
    prod1     = {8'd0, val_q} * 18'd205;
    q1_d      = prod1[17:11];
    q1x10     = ({3'd0, q1_d} << 3) + ({3'd0, q1_d} << 1);
    ones_full = val_q - q1x10;
    ones_d    = ones_full[DigitW-1:0];
    dot_d     = (val_q >= DotThreshold);
  end

  // Second step: tens and hundreds from the registered quotient.
  always_comb begin
    prod2     = {8'd0, q1_q} * 15'd205;
    q2        = prod2[14:11];
    q2x10     = ({3'd0, q2} << 3) + ({3'd0, q2} << 1);
    tens_full = q1_q - q2x10;
    // Quotient of ten means the hundreds digit wraps to zero.
    hund      = (q2 == 4'd10) ? 4'd0 : q2;
    hund_raw  = seg_lookup(hund) | (dot_q ? DotSegment : '0);
  end

  assign wr_valid_o     = (state_q == FrDiv2);
  assign wr_data_o.ones = ~seg_lookup(ones_q);
  assign wr_data_o.tens = ~seg_lookup(tens_full[DigitW-1:0]);
  assign wr_data_o.hund = ~hund_raw;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FrIdle: begin
        if (accept) state_d = FrDiv1;
      end
      FrDiv1: begin
        state_d = FrDiv2;
      end
      FrDiv2: begin
        if (wr_ready_i) state_d = accept ? FrDiv1 : FrIdle;
      end
      default: state_d = FrIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) val_q <= value_i;
    if (state_q == FrDiv1) begin
      q1_q   <= q1_d;
      ones_q <= ones_d;
      dot_q  <= dot_d;
    end
  end

endmodule

[src/ssd_fifo.sv]
// Short queue of segment patterns between the front and the back end.
// Depends on ssd_pkg for the pattern type.
module ssd_fifo #(
  parameter int unsigned Depth = ssd_pkg::FifoDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  ssd_pkg::ssd_pat_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_pop_i,
  output ssd_pkg::ssd_pat_t rd_data_o
);
  import ssd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW2 = $clog2(Depth + 1);

  ssd_pat_t         mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW2-1:0] count_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != CntW2'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

[src/ssd_back.sv]
// Back end: shifts the queued patterns out as 25 pulse beats per value.
// Depends on ssd_pkg; reads from ssd_fifo and drives the result register.
module ssd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_valid_i,
  output logic                        rd_pop_o,
  input  ssd_pkg::ssd_pat_t           rd_data_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [ssd_pkg::TargetW-1:0] target_register_o,
  output logic                        data_bit_o,
  output logic                        last_o
);
  import ssd_pkg::*;

  logic [CntW-1:0]    cnt_q;
  logic               out_valid_q;
  logic [TargetW-1:0] tgt_q, tgt_d;
  logic               bit_q, bit_d;
  logic               last_q, last_d;

  logic               emit;
  logic [3*PatW-1:0]  flat;
  logic [CntW-1:0]    bit_idx;

  // A pulse is produced whenever a pattern waits and the result slot frees.
  assign emit     = rd_valid_i && (!out_valid_q || pop);
  assign rd_pop_o = emit && (cnt_q == CntLast);

  // Select the pulse for the current count, MSB first per register.
  always_comb begin
    flat    = {rd_data_i.ones, rd_data_i.tens, rd_data_i.hund};
    bit_idx = CntW'(3 * PatW - 1) - cnt_q;
    last_d  = (cnt_q == CntLast);
    if (cnt_q < CntTensStart) begin
      tgt_d = TgtOnes;
    end else if (cnt_q < CntHundStart) begin
      tgt_d = TgtTens;
    end else begin
      tgt_d = TgtHund;
    end
    // The extra hundreds pulse repeats the final data bit.
    bit_d = last_d ? rd_data_i.hund[0] : flat[bit_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        cnt_q       <= (cnt_q == CntLast) ? '0 : cnt_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      tgt_q  <= tgt_d;
      bit_q  <= bit_d;
      last_q <= last_d;
    end
  end

  assign empty             = !out_valid_q;
  assign target_register_o = tgt_q;
  assign data_bit_o        = bit_q;
  assign last_o            = last_q;

endmodule
